[rtl/apps_pkg.sv]
// Package with message codes, page numbers and payload types for the power page scheduler.
package apps_pkg;

    // Message type, id and event codes
    localparam logic [7:0] MSG_CHANNEL_EVENT = 8'h40;
    localparam logic [7:0] MSG_ACK_DATA      = 8'h4F;
    localparam logic [7:0] MSG_ID_RF         = 8'h01;
    localparam logic [7:0] EVENT_TX_SLOT     = 8'h03;

    // Function select of an input item
    localparam logic FUNC_RADIO   = 1'b0;
    localparam logic FUNC_MEASURE = 1'b1;

    // Data page numbers
    localparam logic [7:0] PAGE_POWER     = 8'h10;
    localparam logic [7:0] PAGE_MFR_INFO  = 8'h50;
    localparam logic [7:0] PAGE_PROD_INFO = 8'h51;
    localparam logic [7:0] PAGE_CAL_REPLY = 8'h01;

    // Fixed payload bytes
    localparam logic [7:0] BYTE_RESERVED  = 8'hFF;
    localparam logic [7:0] BYTE_CAL_OK    = 8'hAC;
    localparam logic [7:0] BYTE_ONE       = 8'h01;
    localparam logic [7:0] BYTE_ZERO      = 8'h00;

    // Power pages sent in a row before one common page
    localparam int unsigned PATTERN_W = 6;
    localparam logic [PATTERN_W-1:0] POWER_RUN = PATTERN_W'(60);

    // Reset value of the instantaneous power
    localparam logic [15:0] POWER_RESET = 16'd90;

    // One broadcast page: eight bytes, byte 0 is the page number
    typedef logic [7:0] page_t [8];

endpackage

[rtl/ant_power_page_scheduler.sv]
// Bicycle power sensor broadcast page scheduler: builds one 8-byte page per transmit event or calibration request.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one item per accepted edge: either a
//   measurement update (func = 1, power and cadence) or a radio message (func = 0).
//   Transmit-slot channel events on the configured channel give a power page, or a
//   common page after each run of 60 power pages; calibration requests give a
//   calibration reply page. All other items give no result.
//   The output channel (out_valid / out_stall) carries the channel number and the page.
//   The configuration channel (cfg_valid / cfg_ready) writes the channel number; it is
//   always ready. It must be written only while the block is idle; the block does not enforce this.
// Pipeline and throughput:
//   An item is captured in an input register and decoded there; its page is written into
//   the result register when the item moves on. One item is accepted every cycle
//   while in_stall is low; the rate is set by the single input-to-result stage.
// Reset and stalls:
//   Reset clears both stages and restores power 90, cadence 0 and all counters to zero.
//   While the receiver stalls, the result register holds its page and the input
//   register keeps taking items until it holds one that gives a page; then in_stall is raised.
module ant_power_page_scheduler
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  msg_type,
    input  logic [7:0]  msg_channel,
    input  logic [7:0]  msg_id,
    input  logic [7:0]  msg_code,
    input  logic [15:0] power_value,
    input  logic [7:0]  cadence_value,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_channel,
    output logic [7:0]  payload_0,
    output logic [7:0]  payload_1,
    output logic [7:0]  payload_2,
    output logic [7:0]  payload_3,
    output logic [7:0]  payload_4,
    output logic [7:0]  payload_5,
    output logic [7:0]  payload_6,
    output logic [7:0]  payload_7
);

    // Configuration and scheduler state
    logic [7:0]                     channel_reg;
    logic [15:0]                    power_reg;
    logic [15:0]                    power_next;
    logic [7:0]                     cadence_reg;
    logic [7:0]                     cadence_next;
    logic [apps_pkg::PATTERN_W-1:0] pattern_reg;
    logic [apps_pkg::PATTERN_W-1:0] pattern_next;
    logic                           page81_reg;
    logic                           page81_next;
    logic [15:0]                    total_reg;
    logic [15:0]                    total_next;
    logic [7:0]                     events_reg;
    logic [7:0]                     events_next;

    // Input register
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        s1_func_reg;
    logic [7:0]  s1_type_reg;
    logic [7:0]  s1_channel_reg;
    logic [7:0]  s1_id_reg;
    logic [7:0]  s1_code_reg;
    logic [15:0] s1_power_reg;
    logic [7:0]  s1_cadence_reg;

    // Result register
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_channel_reg;
    apps_pkg::page_t      page_reg;
    apps_pkg::page_t      page_next;

    // Decode and handshake
    logic        in_accept;
    logic        match;
    logic        is_tx;
    logic        is_ack;
    logic        produces;
    logic        s1_advance;
    logic [15:0] total_sum;

    assign cfg_ready = 1'b1;

    // Decode of the item held in the input register.
    assign match    = (s1_func_reg == apps_pkg::FUNC_RADIO)
                   && (s1_channel_reg == channel_reg)
                   && (s1_id_reg == apps_pkg::MSG_ID_RF);
    assign is_tx    = match && (s1_type_reg == apps_pkg::MSG_CHANNEL_EVENT)
                   && (s1_code_reg == apps_pkg::EVENT_TX_SLOT);
    assign is_ack   = match && (s1_type_reg == apps_pkg::MSG_ACK_DATA);
    assign produces = is_tx || is_ack;

    // The held item moves on unless its page would overwrite a stalled result.
    assign s1_advance = s1_valid_reg && (!produces || !out_valid_reg || !out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    assign total_sum = total_reg + power_reg;

    // Next state and page for the held item.
    always_comb
    begin
        power_next    = power_reg;
        cadence_next  = cadence_reg;
        pattern_next  = pattern_reg;
        page81_next   = page81_reg;
        total_next    = total_reg;
        events_next   = events_reg;
        page_next     = page_reg;

        if (s1_advance)
        begin
            if (s1_func_reg == apps_pkg::FUNC_MEASURE)
            begin
                power_next   = s1_power_reg;
                cadence_next = s1_cadence_reg;
            end
            else if (is_tx)
            begin
                if (pattern_reg < apps_pkg::POWER_RUN)
                begin
                    // Power page: total already holds this event's power.
                    pattern_next = pattern_reg + 1'b1;
                    total_next   = total_sum;
                    events_next  = events_reg + 8'd1;
                    page_next[0] = apps_pkg::PAGE_POWER;
                    page_next[1] = events_reg;
                    page_next[2] = apps_pkg::BYTE_RESERVED;
                    page_next[3] = cadence_reg;
                    page_next[4] = total_sum[7:0];
                    page_next[5] = total_sum[15:8];
                    page_next[6] = power_reg[7:0];
                    page_next[7] = power_reg[15:8];
                end
                else
                begin
                    // Common page: manufacturer and product info take turns.
                    pattern_next = '0;
                    page81_next  = !page81_reg;
                    page_next[1] = apps_pkg::BYTE_RESERVED;
                    page_next[2] = apps_pkg::BYTE_RESERVED;
                    page_next[3] = apps_pkg::BYTE_ONE;
                    page_next[4] = apps_pkg::BYTE_RESERVED;
                    if (page81_reg)
                    begin
                        page_next[0] = apps_pkg::PAGE_PROD_INFO;
                        page_next[5] = apps_pkg::BYTE_RESERVED;
                        page_next[6] = apps_pkg::BYTE_RESERVED;
                        page_next[7] = apps_pkg::BYTE_RESERVED;
                    end
                    else
                    begin
                        page_next[0] = apps_pkg::PAGE_MFR_INFO;
                        page_next[5] = apps_pkg::BYTE_ZERO;
                        page_next[6] = apps_pkg::BYTE_ONE;
                        page_next[7] = apps_pkg::BYTE_ZERO;
                    end
                end
            end
            else if (is_ack)
            begin
                // Calibration reply page.
                page_next[0] = apps_pkg::PAGE_CAL_REPLY;
                page_next[1] = apps_pkg::BYTE_CAL_OK;
                page_next[2] = apps_pkg::BYTE_RESERVED;
                page_next[3] = apps_pkg::BYTE_RESERVED;
                page_next[4] = apps_pkg::BYTE_RESERVED;
                page_next[5] = apps_pkg::BYTE_RESERVED;
                page_next[6] = apps_pkg::BYTE_ZERO;
                page_next[7] = apps_pkg::BYTE_ZERO;
            end
        end
    end

    // Valid flags of both stages.
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance && produces)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and scheduler state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg   <= '0;
            power_reg     <= apps_pkg::POWER_RESET;
            cadence_reg   <= '0;
            pattern_reg   <= '0;
            page81_reg    <= 1'b0;
            total_reg     <= '0;
            events_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                channel_reg <= cfg_data;
            end
            power_reg     <= power_next;
            cadence_reg   <= cadence_next;
            pattern_reg   <= pattern_next;
            page81_reg    <= page81_next;
            total_reg     <= total_next;
            events_reg    <= events_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg    <= func;
            s1_type_reg    <= msg_type;
            s1_channel_reg <= msg_channel;
            s1_id_reg      <= msg_id;
            s1_code_reg    <= msg_code;
            s1_power_reg   <= power_value;
            s1_cadence_reg <= cadence_value;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (s1_advance && produces)
        begin
            out_channel_reg <= channel_reg;
        end
        page_reg <= page_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign payload_0   = page_reg[0];
    assign payload_1   = page_reg[1];
    assign payload_2   = page_reg[2];
    assign payload_3   = page_reg[3];
    assign payload_4   = page_reg[4];
    assign payload_5   = page_reg[5];
    assign payload_6   = page_reg[6];
    assign payload_7   = page_reg[7];

endmodule
